### src/bmp_row_gray_decoder_core_assert.svh
// Assertion macros for the BMP row gray decoder.
`ifndef BMP_ROW_GRAY_DECODER_CORE_ASSERT_SVH
`define BMP_ROW_GRAY_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Property holds at every edge outside reset.
`define BGD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bgd: assertion failed");
// Antecedent implies consequent in the same cycle.
`define BGD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgd: implication failed");
// Antecedent implies consequent in the next cycle.
`define BGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgd: next-cycle implication failed");
`else
`define BGD_ASSERT(lbl, clk, rst_n, prop)
`define BGD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define BGD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### src/bgd_pkg.sv
// Shared types and constants of the BMP row gray decoder.
`default_nettype none

package bgd_pkg;

  localparam int MAX_WIDTH_DEF     = 4096;
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int QUEUE_DEPTH       = 4;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = CFG_IDX_W'(1);

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  typedef enum logic [1:0] {
    DEPTH_1  = 2'd0,
    DEPTH_4  = 2'd1,
    DEPTH_8  = 2'd2,
    DEPTH_24 = 2'd3
  } bgd_depth_e;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_INDEX,
    OP_RGB
  } bgd_op_e;

  // color component expected next in 24-bit mode
  typedef enum logic [1:0] {
    PH_BLUE,
    PH_GREEN,
    PH_RED
  } bgd_phase_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] palette_index;
    logic [7:0] blue_level;
    logic [7:0] green_level;
    logic [7:0] red_level;
    logic [7:0] data_byte;
  } bgd_in_t;

  typedef struct packed {
    logic [7:0]  gray;
    logic [11:0] column;
    logic        row_end;
    logic        last;
  } bgd_out_t;

  // one unit of work for the back end
  typedef struct packed {
    bgd_op_e    op;
    bgd_depth_e depth;
    logic [7:0] byte_a;    // data byte, or palette index on a load
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [2:0] cnt_m1;    // pixels in this entry minus one
    logic [11:0] col;      // low bits of the first pixel column
    logic       ends_row;  // last pixel of the entry closes the row
  } bgd_entry_t;

endpackage

`default_nettype wire

### src/bgd_front.sv
// Front end: configuration, row/byte bookkeeping and work entry generation.
`default_nettype none

module bgd_front #(
  parameter int MAX_WIDTH = bgd_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  bgd_pkg::bgd_in_t                  in_data_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bgd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bgd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              q_push_o,
  output bgd_pkg::bgd_entry_t               q_entry_o,
  input  logic                              q_ready_i
);
  import bgd_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int BW = $clog2(3 * MAX_WIDTH + 4);

  bgd_depth_e            depth_q, depth_d;
  logic [CFG_DATA_W-1:0] width_q, width_d;
  logic [BW-1:0]         byte_q, byte_d;
  logic [WW-1:0]         col_q, col_d;
  bgd_phase_e            phase_q, phase_d;
  logic [7:0]            blue_q, blue_d;
  logic [7:0]            green_q, green_d;

  logic [WW-1:0] eff_w;
  logic [WW-1:0] avail;
  logic [BW-1:0] nb;
  logic [BW-1:0] row_bytes;
  logic [BW-1:0] byte_inc;
  logic [3:0]    per_pix;
  logic [3:0]    n_pix;
  logic          col_lt_w;
  logic          accept;

  // a register write takes the cycle; hold the request off meanwhile
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !q_ready_i || cfg_valid_i;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    if (width_q == '0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
  end

  // bytes per row, padded to a multiple of four
  always_comb begin
    case (depth_q)
      DEPTH_1:  nb = (BW'(eff_w) + BW'(7)) >> 3;
      DEPTH_4:  nb = (BW'(eff_w) + BW'(1)) >> 1;
      DEPTH_8:  nb = BW'(eff_w);
      default:  nb = BW'(eff_w) + (BW'(eff_w) << 1);
    endcase
    row_bytes = (nb + BW'(3)) & ~BW'(3);
  end

  assign byte_inc = byte_q + BW'(1);
  assign col_lt_w = col_q < eff_w;
  assign avail    = eff_w - col_q;

  always_comb begin
    case (depth_q)
      DEPTH_1: per_pix = 4'd8;
      DEPTH_4: per_pix = 4'd2;
      default: per_pix = 4'd1;
    endcase
    if (!col_lt_w) begin
      n_pix = 4'd0;
    end else if (avail >= WW'(per_pix)) begin
      n_pix = per_pix;
    end else begin
      n_pix = 4'(avail);
    end
  end

  always_comb begin
    depth_d = depth_q;
    width_d = width_q;
    byte_d  = byte_q;
    col_d   = col_q;
    phase_d = phase_q;
    blue_d  = blue_q;
    green_d = green_q;

    q_push_o           = 1'b0;
    q_entry_o.op       = OP_LOAD;
    q_entry_o.depth    = depth_q;
    q_entry_o.byte_a   = (in_data_i.mode == MODE_DATA) ? in_data_i.data_byte
                                                       : in_data_i.palette_index;
    q_entry_o.blue     = (in_data_i.mode == MODE_DATA) ? blue_q : in_data_i.blue_level;
    q_entry_o.green    = (in_data_i.mode == MODE_DATA) ? green_q : in_data_i.green_level;
    q_entry_o.red      = (in_data_i.mode == MODE_DATA) ? in_data_i.data_byte
                                                       : in_data_i.red_level;
    q_entry_o.cnt_m1   = 3'd0;
    q_entry_o.col      = 12'(col_q);
    q_entry_o.ends_row = 1'b0;

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_DEPTH) begin
        depth_d = bgd_depth_e'(cfg_data_i[1:0]);
        byte_d  = '0;
        col_d   = '0;
        phase_d = PH_BLUE;
      end else if (cfg_index_i == CFG_WIDTH) begin
        width_d = cfg_data_i;
        byte_d  = '0;
        col_d   = '0;
        phase_d = PH_BLUE;
      end
    end else if (accept) begin
      if (in_data_i.mode == MODE_LOAD) begin
        q_push_o = 1'b1;
      end else begin
        if (depth_q == DEPTH_24) begin
          if (col_lt_w) begin
            case (phase_q)
              PH_BLUE: begin
                blue_d  = in_data_i.data_byte;
                phase_d = PH_GREEN;
              end
              PH_GREEN: begin
                green_d = in_data_i.data_byte;
                phase_d = PH_RED;
              end
              default: begin
                q_push_o           = 1'b1;
                q_entry_o.op       = OP_RGB;
                q_entry_o.ends_row = (col_q + WW'(1)) == eff_w;
                col_d              = col_q + WW'(1);
                phase_d            = PH_BLUE;
              end
            endcase
          end
        end else if (n_pix != 4'd0) begin
          q_push_o           = 1'b1;
          q_entry_o.op       = OP_INDEX;
          q_entry_o.cnt_m1   = 3'(n_pix - 4'd1);
          q_entry_o.ends_row = (col_q + WW'(n_pix)) == eff_w;
          col_d              = col_q + WW'(n_pix);
        end
        if (byte_inc >= row_bytes) begin
          byte_d  = '0;
          col_d   = '0;
          phase_d = PH_BLUE;
        end else begin
          byte_d = byte_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= DEPTH_8;
      width_q <= CFG_DATA_W'(1);
      byte_q  <= '0;
      col_q   <= '0;
      phase_q <= PH_BLUE;
      blue_q  <= '0;
      green_q <= '0;
    end else begin
      depth_q <= depth_d;
      width_q <= width_d;
      byte_q  <= byte_d;
      col_q   <= col_d;
      phase_q <= phase_d;
      blue_q  <= blue_d;
      green_q <= green_d;
    end
  end

endmodule

`default_nettype wire

### src/bgd_queue.sv
// Short entry queue between the front and back ends.
`default_nettype none

module bgd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  bgd_pkg::bgd_entry_t entry_i,
  output logic                ready_o,
  output logic                valid_o,
  output bgd_pkg::bgd_entry_t head_o,
  input  logic                pop_i
);
  import bgd_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  bgd_entry_t    slots_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push;
  logic          do_pop;

  assign ready_o = cnt_q != CW'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = slots_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### src/bgd_back.sv
// Back end: palette store, gray conversion and one-pixel-per-cycle output while the output is not stalled.
`default_nettype none

module bgd_back #(
  parameter int PALETTE_DEPTH = bgd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  bgd_pkg::bgd_entry_t q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bgd_pkg::bgd_out_t   out_data_o
);
  import bgd_pkg::*;

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  localparam logic [15:0] W_RED   = 16'd77;
  localparam logic [15:0] W_GREEN = 16'd151;
  localparam logic [15:0] W_BLUE  = 16'd28;

  logic [7:0] pal_mem [PALETTE_DEPTH];

  logic [2:0]  k_q, k_d;
  logic        out_valid_q, out_valid_d;
  logic        from_pal_q;
  logic        oob_q;
  logic [7:0]  gray_q;
  logic [7:0]  rd_q;
  logic [11:0] col_q;
  logic        row_end_q;
  logic        last_q;

  logic        can_out;
  logic        is_load;
  logic        fire;
  logic        pix;
  logic        end_k;
  logic [7:0]  pidx;
  logic        pidx_oob;
  logic        load_oob;
  logic        mem_we;
  logic        mem_re;
  logic [15:0] wsum;
  logic [7:0]  conv_gray;

  // weights sum to 256, so the top byte never overflows
  assign wsum = 16'(q_head_i.red) * W_RED + 16'(q_head_i.green) * W_GREEN
              + 16'(q_head_i.blue) * W_BLUE;
  assign conv_gray = wsum[15:8];

  assign can_out = !out_valid_q || !out_stall_i;
  assign is_load = q_head_i.op == OP_LOAD;
  assign fire    = q_valid_i && (is_load || can_out);
  assign pix     = fire && !is_load;
  assign end_k   = k_q == q_head_i.cnt_m1;
  assign q_pop_o = fire && (is_load || end_k);

  // palette field, most significant first
  always_comb begin
    case (q_head_i.depth)
      DEPTH_1: pidx = {7'd0, q_head_i.byte_a[3'd7 - k_q]};
      DEPTH_4: pidx = k_q[0] ? {4'd0, q_head_i.byte_a[3:0]}
                             : {4'd0, q_head_i.byte_a[7:4]};
      default: pidx = q_head_i.byte_a;
    endcase
  end

  assign pidx_oob = 9'(pidx) >= 9'(PALETTE_DEPTH);
  assign load_oob = 9'(q_head_i.byte_a) >= 9'(PALETTE_DEPTH);
  assign mem_we   = fire && is_load && !load_oob;
  assign mem_re   = pix && (q_head_i.op == OP_INDEX);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pal_mem[q_head_i.byte_a[AW-1:0]] <= conv_gray;
    end
    if (mem_re) begin
      rd_q <= pal_mem[pidx[AW-1:0]];
    end
  end

  always_comb begin
    k_d = k_q;
    if (pix) begin
      k_d = end_k ? 3'd0 : k_q + 3'd1;
    end
    if (pix) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix) begin
      from_pal_q <= q_head_i.op == OP_INDEX;
      oob_q      <= pidx_oob;
      gray_q     <= conv_gray;
      col_q      <= q_head_i.col + 12'(k_q);
      row_end_q  <= q_head_i.ends_row && end_k;
      last_q     <= end_k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_data_o.gray    = from_pal_q ? (oob_q ? 8'd0 : rd_q) : gray_q;
  assign out_data_o.column  = col_q;
  assign out_data_o.row_end = row_end_q;
  assign out_data_o.last    = last_q;

endmodule

`default_nettype wire

### src/bmp_row_gray_decoder_core.sv
// Top level of the BMP row gray decoder.
`default_nettype none
`include "bmp_row_gray_decoder_core_assert.svh"

// Decodes BMP pixel rows into 8-bit gray pixels. The front end takes one
// request per cycle (palette load or row byte) while its four-entry queue
// has room and no register write is offered; the back end emits one pixel
// per cycle while the output is not stalled. A byte yields 8 pixels at 1 bpp,
// 2 at 4 bpp and 1 at 8 bpp (fewer at the end of a row), and a 24-bit pixel
// comes from every third byte. Palette loads produce no output pixel;
// padding and bytes that gather color components produce no queue entry.
// With an empty queue, the first pixel of a byte passes through a queue slot
// and the back-end output registers before it is offered. Gray is
// (77*R + 151*G + 28*B) >> 8. The palette is not cleared at reset; entries
// must be loaded before use. A depth or width write restarts the row
// position.
module bmp_row_gray_decoder_core #(
  parameter int MAX_WIDTH     = bgd_pkg::MAX_WIDTH_DEF,
  parameter int PALETTE_DEPTH = bgd_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bgd_pkg::bgd_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bgd_pkg::bgd_out_t              out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bgd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bgd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bgd_pkg::*;

  logic       q_push;
  logic       q_ready;
  logic       q_valid;
  logic       q_pop;
  bgd_entry_t q_entry;
  bgd_entry_t q_head;

  bgd_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .q_push_o   (q_push),
    .q_entry_o  (q_entry),
    .q_ready_i  (q_ready)
  );

  bgd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .head_o (q_head),
    .pop_i  (q_pop)
  );

  bgd_back #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // a request is never pushed into a full queue
  `BGD_ASSERT_IMPL(a_push_room, clk_i, rst_ni, q_push, q_ready)
  // the pixel closing a row always closes its request
  `BGD_ASSERT_IMPL(a_row_end_last, clk_i, rst_ni,
                   out_valid_o && out_data_o.row_end, out_data_o.last)
  // pixels of one request follow without a bubble
  `BGD_ASSERT_NEXT(a_no_bubble, clk_i, rst_ni,
                   out_valid_o && !out_stall_i && !out_data_o.last, out_valid_o)

endmodule

`default_nettype wire
